// ----- rtl/core/acpc_pkg.sv -----
package acpc_pkg;

  localparam int unsigned ColorW = 16;
  localparam int unsigned NibW   = 4;
  localparam int unsigned WeightW = 5;
  localparam int unsigned CfgIdxW = 3;

  // Nibble positions in a GBAR4444 word.
  localparam int unsigned RLsb = 0;
  localparam int unsigned ALsb = 4;
  localparam int unsigned BLsb = 8;
  localparam int unsigned GLsb = 12;

  localparam logic [WeightW-1:0] WeightSum   = 5'd17;
  localparam logic [NibW-1:0]    AlphaOpaque = 4'hf;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MULTICOLOR_ENABLE = 3'd0,
    REG_BACKGROUND_ENABLE = 3'd1,
    REG_PER_TILE_COLORS   = 3'd2,
    REG_FORE_COLOR        = 3'd3,
    REG_BACK_COLOR        = 3'd4
  } acpc_reg_e;

  typedef struct packed {
    logic              multicolor_enable;
    logic              background_enable;
    logic              per_tile_colors;
    logic [ColorW-1:0] fore_color;
    logic [ColorW-1:0] back_color;
  } acpc_cfg_t;

  typedef struct packed {
    logic [ColorW-1:0] src_color;
    logic [ColorW-1:0] dst_color;
    logic [ColorW-1:0] tile_fore;
    logic [ColorW-1:0] tile_back;
  } acpc_pix_t;

  // Weighted mix of one channel: (a*s + (17-a)*d) >> 4. The weights sum to 17,
  // so the sum never exceeds 255 and the result fits a nibble.
  function automatic logic [NibW-1:0] blend_nib(logic [WeightW-1:0] a,
                                                logic [NibW-1:0] s,
                                                logic [NibW-1:0] d);
    logic [WeightW-1:0] ia;
    logic [8:0]         ps;
    logic [8:0]         pd;
    logic [8:0]         sum;
    ia  = WeightSum - a;
    ps  = 9'(a) * 9'(s);
    pd  = 9'(ia) * 9'(d);
    sum = ps + pd;
    return sum[NibW+3:4];
  endfunction

endpackage

// ----- rtl/core/acpc_if.sv -----
interface acpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [acpc_pkg::ColorW-1:0]   src_color;
  logic [acpc_pkg::ColorW-1:0]   dst_color;
  logic [acpc_pkg::ColorW-1:0]   tile_fore;
  logic [acpc_pkg::ColorW-1:0]   tile_back;

  modport source (output valid, src_color, dst_color, tile_fore, tile_back, input ready);
  modport sink (input valid, src_color, dst_color, tile_fore, tile_back, output ready);
endinterface

interface acpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [acpc_pkg::ColorW-1:0]   blended_color;

  modport source (output valid, blended_color, input ready);
  modport sink (input valid, blended_color, output ready);
endinterface

interface acpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [acpc_pkg::CfgIdxW-1:0]  reg_index;
  logic [acpc_pkg::ColorW-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/core/acpc_cfg_regs.sv -----
module acpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [acpc_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [acpc_pkg::ColorW-1:0]   wr_data_i,
  output acpc_pkg::acpc_cfg_t           cfg_o
);

  acpc_pkg::acpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        acpc_pkg::REG_MULTICOLOR_ENABLE: cfg_d.multicolor_enable = wr_data_i[0];
        acpc_pkg::REG_BACKGROUND_ENABLE: cfg_d.background_enable = wr_data_i[0];
        acpc_pkg::REG_PER_TILE_COLORS:   cfg_d.per_tile_colors   = wr_data_i[0];
        acpc_pkg::REG_FORE_COLOR:        cfg_d.fore_color        = wr_data_i;
        acpc_pkg::REG_BACK_COLOR:        cfg_d.back_color        = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/acpc_blend.sv -----
module acpc_blend (
  input  acpc_pkg::acpc_cfg_t         cfg_i,
  input  acpc_pkg::acpc_pix_t         pix_i,
  output logic [acpc_pkg::ColorW-1:0] color_o
);

  localparam int unsigned NW = acpc_pkg::NibW;

  logic [acpc_pkg::ColorW-1:0]  fg, bg, src;
  logic [acpc_pkg::WeightW-1:0] a;

  always_comb begin
    fg = cfg_i.per_tile_colors ? pix_i.tile_fore : cfg_i.fore_color;
    bg = cfg_i.per_tile_colors ? pix_i.tile_back : cfg_i.back_color;
    src = pix_i.src_color;
    if (pix_i.src_color[acpc_pkg::ALsb +: NW] != '0) begin
      if (!cfg_i.multicolor_enable) begin
        src = fg;
      end
    end else if (cfg_i.background_enable) begin
      src = bg;
    end
  end

  // The weight comes from the alpha of the substituted color, if any.
  assign a = {1'b0, src[acpc_pkg::ALsb +: NW]} + acpc_pkg::WeightW'(1);

  assign color_o[acpc_pkg::RLsb +: NW] = acpc_pkg::blend_nib(a,
      src[acpc_pkg::RLsb +: NW], pix_i.dst_color[acpc_pkg::RLsb +: NW]);
  assign color_o[acpc_pkg::GLsb +: NW] = acpc_pkg::blend_nib(a,
      src[acpc_pkg::GLsb +: NW], pix_i.dst_color[acpc_pkg::GLsb +: NW]);
  assign color_o[acpc_pkg::BLsb +: NW] = acpc_pkg::blend_nib(a,
      src[acpc_pkg::BLsb +: NW], pix_i.dst_color[acpc_pkg::BLsb +: NW]);
  assign color_o[acpc_pkg::ALsb +: NW] = acpc_pkg::AlphaOpaque;

endmodule

// ----- rtl/core/argb4444_pixel_compositor_top.sv -----
// GBAR4444 pixel compositor, the per-pixel blend stage of a blitter.
// Channels: pix_in_i carries the source, destination and per-tile colors of
// one pixel per beat; pix_out_o returns the blended destination word; cfg_i
// writes the mode bits and the global foreground and background colors.
// Configuration beats are always taken and should only be sent while the
// stage holds no pixel.
// An accepted input beat is registered at the input and then at the output.
// Throughput is one pixel per cycle while the receiver does not stall: an
// input register feeds the color select and the three 5x4-bit channel
// blends, which land in the output register; both advance in the same cycle.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more pixel before ready drops.
// Reset clears both pipeline valid bits and all configuration registers.
module argb4444_pixel_compositor_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  acpc_in_if.sink    pix_in_i,
  acpc_out_if.source pix_out_o,
  acpc_cfg_if.sink   cfg_i
);

  acpc_pkg::acpc_cfg_t cfg;
  acpc_pkg::acpc_pix_t pix_q, pix_d;
  logic                in_valid_q;
  logic                out_valid_q;
  logic [acpc_pkg::ColorW-1:0] out_color_q, out_color_d;
  logic                out_ready, in_ready, in_fire;

  assign cfg_i.ready = 1'b1;

  acpc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  assign out_ready = !out_valid_q || pix_out_o.ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_fire   = pix_in_i.valid && in_ready;

  assign pix_in_i.ready = in_ready;

  assign pix_d.src_color = pix_in_i.src_color;
  assign pix_d.dst_color = pix_in_i.dst_color;
  assign pix_d.tile_fore = pix_in_i.tile_fore;
  assign pix_d.tile_back = pix_in_i.tile_back;

  acpc_blend u_blend (
    .cfg_i   (cfg),
    .pix_i   (pix_q),
    .color_o (out_color_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= pix_in_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= pix_d;
    end
    if (out_ready && in_valid_q) begin
      out_color_q <= out_color_d;
    end
  end

  assign pix_out_o.valid         = out_valid_q;
  assign pix_out_o.blended_color = out_color_q;

`ifndef SYNTH
  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_color_q[acpc_pkg::ALsb +: acpc_pkg::NibW] == acpc_pkg::AlphaOpaque)
    else $error("output alpha nibble is not opaque");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !pix_out_o.ready) |=> in_valid_q && out_valid_q)
    else $error("pixel lost while the output was stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !(in_valid_q && out_valid_q && !pix_out_o.ready))
    else $error("input accepted into a full pipeline");
`endif

endmodule
